// ----- rtl/core/tsi_pkg.sv -----
// ----------------------------------------------------------------------------
// tsi_pkg
// Shared types and constants for the two-axis step interpolator.
// ----------------------------------------------------------------------------
package tsi_pkg;

  localparam int DELTA_BITS = 24;
  localparam int MAG_BITS   = 23;
  localparam int DIFF_BITS  = 25;

  localparam logic [MAG_BITS-1:0] MAG_MAX = 23'h7f_ffff;

  typedef enum logic [1:0] {
    CMD_MOVE = 2'd0,
    CMD_TICK = 2'd1,
    CMD_HOME = 2'd2
  } cmd_t;

  typedef struct packed {
    logic load;
    logic home;
    logic tick;
  } axis_ctl_t;

endpackage

// ----- rtl/core/tsi_axis.sv -----
// ----------------------------------------------------------------------------
// tsi_axis
// One axis: step decision by a running cross-product error term, remaining
// step count, direction and wrapping position counter.
// ----------------------------------------------------------------------------
module tsi_axis #(
  parameter int POSITION_BITS = 24
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  tsi_pkg::axis_ctl_t                     ctl,
  input  logic signed [tsi_pkg::DELTA_BITS-1:0]  delta,
  input  logic [tsi_pkg::MAG_BITS-1:0]           major,
  output logic [tsi_pkg::MAG_BITS-1:0]           load_mag,
  output logic                                   step,
  output logic                                   dir_nxt,
  output logic [POSITION_BITS-1:0]               pos_nxt
);

  localparam int NW = ((POSITION_BITS > tsi_pkg::DELTA_BITS) ?
                       POSITION_BITS : tsi_pkg::DELTA_BITS) + 1;
  localparam logic signed [NW-1:0] SAT_HI = NW'(tsi_pkg::MAG_MAX);
  localparam logic signed [NW-1:0] SAT_LO = -SAT_HI;
  localparam logic [tsi_pkg::DELTA_BITS-1:0] DELTA_MIN =
    {1'b1, {(tsi_pkg::DELTA_BITS-1){1'b0}}};

  logic [tsi_pkg::MAG_BITS-1:0]          remaining_r;
  logic [tsi_pkg::MAG_BITS-1:0]          total_r;
  logic signed [tsi_pkg::DIFF_BITS-1:0]  diff_r;
  logic                                  dir_r;
  logic [POSITION_BITS-1:0]              pos_r;

  logic signed [NW-1:0]                  pos_ext;
  logic signed [NW-1:0]                  pos_neg;
  logic signed [NW-1:0]                  pos_sat;
  logic signed [tsi_pkg::DELTA_BITS-1:0] sel_delta;
  logic [tsi_pkg::DELTA_BITS-1:0]        neg_delta;
  logic signed [tsi_pkg::DIFF_BITS-1:0]  diff_nxt;

  // home target: negated position, clamped to +/-MAG_MAX
  always_comb begin
    pos_ext = {{(NW-POSITION_BITS){pos_r[POSITION_BITS-1]}}, pos_r};
    pos_neg = -pos_ext;
    if (pos_neg > SAT_HI) begin
      pos_sat = SAT_HI;
    end else if (pos_neg < SAT_LO) begin
      pos_sat = SAT_LO;
    end else begin
      pos_sat = pos_neg;
    end
    sel_delta = ctl.home ? pos_sat[tsi_pkg::DELTA_BITS-1:0] : delta;
    neg_delta = -sel_delta;
    if (!sel_delta[tsi_pkg::DELTA_BITS-1]) begin
      load_mag = sel_delta[tsi_pkg::MAG_BITS-1:0];
    end else if (sel_delta == DELTA_MIN) begin
      load_mag = tsi_pkg::MAG_MAX;
    end else begin
      load_mag = neg_delta[tsi_pkg::MAG_BITS-1:0];
    end
  end

  // diff tracks remaining*major - index*total
  always_comb begin
    step     = ctl.tick && (remaining_r != '0) && !diff_r[tsi_pkg::DIFF_BITS-1];
    diff_nxt = diff_r + tsi_pkg::DIFF_BITS'(total_r)
               - (step ? tsi_pkg::DIFF_BITS'(major) : '0);
    dir_nxt  = ctl.load ? (!sel_delta[tsi_pkg::DELTA_BITS-1] && (sel_delta != '0))
                        : dir_r;
    if (step) begin
      pos_nxt = dir_r ? pos_r + 1'b1 : pos_r - 1'b1;
    end else begin
      pos_nxt = pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r       <= 1'b0;
      pos_r       <= '0;
      remaining_r <= '0;
      total_r     <= '0;
      diff_r      <= '0;
    end else begin
      dir_r <= dir_nxt;
      pos_r <= pos_nxt;
      if (ctl.load) begin
        remaining_r <= load_mag;
        total_r     <= load_mag;
        diff_r      <= tsi_pkg::DIFF_BITS'(load_mag);
      end else if (ctl.tick && (remaining_r != '0)) begin
        diff_r <= diff_nxt;
        if (step) begin
          remaining_r <= remaining_r - 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/core/two_axis_step_interpolator_unit.sv -----
// ----------------------------------------------------------------------------
// two_axis_step_interpolator_unit
// Two-axis linear step interpolator with move, tick and home commands.
// The command is registered in the s1 registers, the result in the output register.
// Throughput: one transaction per cycle unless out_stall holds the output;
// the per-axis error update and position counters are combinational.
// Reset: synchronous active-low; idle, positions and directions cleared.
// ----------------------------------------------------------------------------
module two_axis_step_interpolator_unit #(
  parameter int POSITION_BITS = 24
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [1:0]                             in_command,
  input  logic signed [tsi_pkg::DELTA_BITS-1:0]  in_delta_x,
  input  logic signed [tsi_pkg::DELTA_BITS-1:0]  in_delta_y,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   out_step_x,
  output logic                                   out_dir_x,
  output logic                                   out_step_y,
  output logic                                   out_dir_y,
  output logic signed [tsi_pkg::DELTA_BITS-1:0]  out_position_x,
  output logic signed [tsi_pkg::DELTA_BITS-1:0]  out_position_y,
  output logic                                   out_busy_res,
  output logic                                   out_accepted
);

  logic                                  s1_valid_r;
  logic [1:0]                            s1_cmd_r;
  logic signed [tsi_pkg::DELTA_BITS-1:0] s1_dx_r;
  logic signed [tsi_pkg::DELTA_BITS-1:0] s1_dy_r;

  logic                                  active_r;
  logic [tsi_pkg::MAG_BITS-1:0]          major_r;
  logic [tsi_pkg::MAG_BITS-1:0]          index_r;

  logic                                  adv;
  logic                                  is_load;
  logic                                  is_home;
  logic                                  is_tick;
  tsi_pkg::axis_ctl_t                    ctl;
  logic [tsi_pkg::MAG_BITS-1:0]          mag_x;
  logic [tsi_pkg::MAG_BITS-1:0]          mag_y;
  logic [tsi_pkg::MAG_BITS-1:0]          major_new;
  logic                                  step_x;
  logic                                  step_y;
  logic                                  dir_x_nxt;
  logic                                  dir_y_nxt;
  logic [POSITION_BITS-1:0]              pos_x_nxt;
  logic [POSITION_BITS-1:0]              pos_y_nxt;
  logic                                  active_nxt;

  assign adv      = s1_valid_r && (!out_valid || !out_stall);
  assign in_stall = s1_valid_r && !adv;

  always_comb begin
    is_load = 1'b0;
    is_home = 1'b0;
    is_tick = 1'b0;
    unique case (s1_cmd_r)
      tsi_pkg::CMD_MOVE: is_load = adv && !active_r;
      tsi_pkg::CMD_HOME: begin
        is_load = adv && !active_r;
        is_home = 1'b1;
      end
      tsi_pkg::CMD_TICK: is_tick = adv && active_r;
      default: ;
    endcase
    ctl.load  = is_load;
    ctl.home  = is_home;
    ctl.tick  = is_tick;
    major_new = (mag_x > mag_y) ? mag_x : mag_y;
    if (is_load) begin
      active_nxt = (major_new != '0);
    end else if (is_tick && (index_r == '0)) begin
      active_nxt = 1'b0;
    end else begin
      active_nxt = active_r;
    end
  end

  tsi_axis #(.POSITION_BITS(POSITION_BITS)) u_axis_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .delta    (s1_dx_r),
    .major    (major_r),
    .load_mag (mag_x),
    .step     (step_x),
    .dir_nxt  (dir_x_nxt),
    .pos_nxt  (pos_x_nxt)
  );

  tsi_axis #(.POSITION_BITS(POSITION_BITS)) u_axis_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .delta    (s1_dy_r),
    .major    (major_r),
    .load_mag (mag_y),
    .step     (step_y),
    .dir_nxt  (dir_y_nxt),
    .pos_nxt  (pos_y_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid  <= 1'b0;
      active_r   <= 1'b0;
      major_r    <= '0;
      index_r    <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      active_r <= active_nxt;
      if (is_load) begin
        major_r <= major_new;
        index_r <= (major_new != '0) ? major_new - 1'b1 : '0;
      end else if (is_tick && (index_r != '0)) begin
        index_r <= index_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_cmd_r <= in_command;
      s1_dx_r  <= in_delta_x;
      s1_dy_r  <= in_delta_y;
    end
    if (adv) begin
      out_step_x     <= step_x;
      out_dir_x      <= dir_x_nxt;
      out_step_y     <= step_y;
      out_dir_y      <= dir_y_nxt;
      out_position_x <= tsi_pkg::DELTA_BITS'(pos_x_nxt);
      out_position_y <= tsi_pkg::DELTA_BITS'(pos_y_nxt);
      out_busy_res   <= active_nxt;
      out_accepted   <= is_load;
    end
  end

endmodule

// ----- verif/two_axis_step_interpolator_unit_test.sv -----
// ----------------------------------------------------------------------------
// two_axis_step_interpolator_unit_test
// Self-checking bench for the two-axis step interpolator. A short table of
// directed commands is followed by random move, tick and home sequences with
// random gaps and back-pressure on both channels. Each result transaction is
// checked by field against an in-bench interpolation model or a typed row.
// ----------------------------------------------------------------------------
module two_axis_step_interpolator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_NOP   = 2'd3;
  localparam int         MAG_LIM   = int'(tsi_pkg::MAG_MAX);
  localparam int         RAND_CMDS = 800;
  localparam int         LIMIT     = 200000;

  typedef struct packed {
    logic                                  step_x;
    logic                                  dir_x;
    logic                                  step_y;
    logic                                  dir_y;
    logic signed [tsi_pkg::DELTA_BITS-1:0] pos_x;
    logic signed [tsi_pkg::DELTA_BITS-1:0] pos_y;
    logic                                  busy;
    logic                                  accepted;
  } motion_res_t;

  typedef struct {
    logic [1:0]                            cmd;
    logic signed [tsi_pkg::DELTA_BITS-1:0] dx;
    logic signed [tsi_pkg::DELTA_BITS-1:0] dy;
    bit                                    typed;
    motion_res_t                           res;
  } cmd_row_t;

  logic                                  clk;
  logic                                  rst_n;
  logic                                  in_valid;
  logic                                  in_stall;
  logic [1:0]                            in_command;
  logic signed [tsi_pkg::DELTA_BITS-1:0] in_delta_x;
  logic signed [tsi_pkg::DELTA_BITS-1:0] in_delta_y;
  logic                                  out_valid;
  logic                                  out_stall;
  logic                                  out_step_x;
  logic                                  out_dir_x;
  logic                                  out_step_y;
  logic                                  out_dir_y;
  logic signed [tsi_pkg::DELTA_BITS-1:0] out_position_x;
  logic signed [tsi_pkg::DELTA_BITS-1:0] out_position_y;
  logic                                  out_busy_res;
  logic                                  out_accepted;

  // interpolation model state
  logic [tsi_pkg::MAG_BITS-1:0]          rem_x = '0, rem_y = '0, tot_x = '0, tot_y = '0;
  logic [tsi_pkg::MAG_BITS-1:0]          major_len = '0, iter_idx = '0;
  logic [1:0]                            dir_bits = '0;
  logic signed [tsi_pkg::DELTA_BITS-1:0] cnt_x = '0, cnt_y = '0;
  logic                                  moving = 1'b0;

  motion_res_t motion_q[$];
  int          n_sent = 0;
  int          n_rx = 0;
  int          errors = 0;
  int          cycles = 0;

  cmd_row_t cmd_tbl[] = '{
    '{tsi_pkg::CMD_TICK, 24'sd0,      24'sd0,      1'b1, '{0, 0, 0, 0, 0, 0, 0, 0}},
    '{CMD_NOP,           24'sh7fffff, 24'sh800000, 1'b1, '{0, 0, 0, 0, 0, 0, 0, 0}},
    '{tsi_pkg::CMD_HOME, 24'sd0,      24'sd0,      1'b1, '{0, 0, 0, 0, 0, 0, 0, 1}},
    '{tsi_pkg::CMD_MOVE, 24'sd0,      24'sd0,      1'b1, '{0, 0, 0, 0, 0, 0, 0, 1}},
    '{tsi_pkg::CMD_MOVE, 24'sd3,      24'sd0,      1'b1, '{0, 1, 0, 0, 0, 0, 1, 1}},
    '{tsi_pkg::CMD_MOVE, 24'sh800000, 24'sh7fffff, 1'b1, '{0, 1, 0, 0, 0, 0, 1, 0}},
    '{CMD_NOP,           -24'sd1,     24'sd1,      1'b0, '0},
    '{tsi_pkg::CMD_HOME, 24'sd5,      -24'sd5,     1'b0, '0},
    '{tsi_pkg::CMD_TICK, 24'sd0,      24'sd0,      1'b0, '0},
    '{tsi_pkg::CMD_TICK, 24'sh7fffff, 24'sh800000, 1'b0, '0},
    '{tsi_pkg::CMD_TICK, 24'sd0,      24'sd0,      1'b0, '0},
    '{tsi_pkg::CMD_MOVE, -24'sd2,     24'sd5,      1'b0, '0},
    '{tsi_pkg::CMD_TICK, 24'sd0,      24'sd0,      1'b0, '0},
    '{tsi_pkg::CMD_TICK, 24'sd0,      24'sd0,      1'b0, '0},
    '{tsi_pkg::CMD_TICK, 24'sd0,      24'sd0,      1'b0, '0},
    '{tsi_pkg::CMD_TICK, 24'sd0,      24'sd0,      1'b0, '0},
    '{tsi_pkg::CMD_TICK, 24'sd0,      24'sd0,      1'b0, '0},
    '{tsi_pkg::CMD_HOME, 24'sd0,      24'sd0,      1'b0, '0},
    '{tsi_pkg::CMD_TICK, 24'sd0,      24'sd0,      1'b0, '0},
    '{tsi_pkg::CMD_TICK, 24'sd0,      24'sd0,      1'b0, '0},
    '{tsi_pkg::CMD_TICK, 24'sd0,      24'sd0,      1'b0, '0},
    '{tsi_pkg::CMD_TICK, 24'sd0,      24'sd0,      1'b0, '0},
    '{tsi_pkg::CMD_TICK, 24'sd0,      24'sd0,      1'b0, '0},
    '{tsi_pkg::CMD_MOVE, 24'sd1,      -24'sd1,     1'b0, '0},
    '{tsi_pkg::CMD_TICK, 24'sd0,      24'sd0,      1'b0, '0}
  };

  two_axis_step_interpolator_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_delta_x     (in_delta_x),
    .in_delta_y     (in_delta_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_step_x     (out_step_x),
    .out_dir_x      (out_dir_x),
    .out_step_y     (out_step_y),
    .out_dir_y      (out_dir_y),
    .out_position_x (out_position_x),
    .out_position_y (out_position_y),
    .out_busy_res   (out_busy_res),
    .out_accepted   (out_accepted)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("%0t: timeout", $time);
      $display("two_axis_step_interpolator_unit_test NOT OK");
      $finish;
    end
  end

  function automatic void load_motion(int dx, int dy);
    int ax, ay;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    if (ax > MAG_LIM) ax = MAG_LIM;
    if (ay > MAG_LIM) ay = MAG_LIM;
    dir_bits  = {dy > 0, dx > 0};
    rem_x     = ax[tsi_pkg::MAG_BITS-1:0];
    tot_x     = ax[tsi_pkg::MAG_BITS-1:0];
    rem_y     = ay[tsi_pkg::MAG_BITS-1:0];
    tot_y     = ay[tsi_pkg::MAG_BITS-1:0];
    major_len = (ax > ay) ? ax[tsi_pkg::MAG_BITS-1:0] : ay[tsi_pkg::MAG_BITS-1:0];
    moving    = (major_len != '0);
    iter_idx  = moving ? major_len - 1'b1 : '0;
  endfunction

  function automatic int home_delta(logic signed [tsi_pkg::DELTA_BITS-1:0] pos);
    int v;
    v = -int'(pos);
    if (v > MAG_LIM) v = MAG_LIM;
    if (v < -MAG_LIM) v = -MAG_LIM;
    return v;
  endfunction

  function automatic motion_res_t interp_step(
    logic [1:0]                            cmd,
    logic signed [tsi_pkg::DELTA_BITS-1:0] dx,
    logic signed [tsi_pkg::DELTA_BITS-1:0] dy
  );
    motion_res_t     r;
    longint unsigned mj, idx;
    r  = '0;
    mj = longint'(major_len);
    idx = longint'(iter_idx);
    case (cmd)
      tsi_pkg::CMD_MOVE, tsi_pkg::CMD_HOME: begin
        if (!moving) begin
          if (cmd == tsi_pkg::CMD_MOVE) load_motion(int'(dx), int'(dy));
          else load_motion(home_delta(cnt_x), home_delta(cnt_y));
          r.accepted = 1'b1;
        end
      end
      tsi_pkg::CMD_TICK: begin
        if (moving) begin
          if (rem_x != '0 && longint'(rem_x) * mj >= idx * longint'(tot_x)) begin
            r.step_x = 1'b1;
            rem_x    = rem_x - 1'b1;
            cnt_x    = dir_bits[0] ? cnt_x + 1'b1 : cnt_x - 1'b1;
          end
          if (rem_y != '0 && longint'(rem_y) * mj >= idx * longint'(tot_y)) begin
            r.step_y = 1'b1;
            rem_y    = rem_y - 1'b1;
            cnt_y    = dir_bits[1] ? cnt_y + 1'b1 : cnt_y - 1'b1;
          end
          if (iter_idx == '0) moving = 1'b0;
          else iter_idx = iter_idx - 1'b1;
        end
      end
      default: ;
    endcase
    r.dir_x = dir_bits[0];
    r.dir_y = dir_bits[1];
    r.pos_x = cnt_x;
    r.pos_y = cnt_y;
    r.busy  = moving;
    return r;
  endfunction

  function automatic logic signed [tsi_pkg::DELTA_BITS-1:0] short_delta();
    int mag;
    mag = $urandom_range(0, ($urandom_range(0, 7) == 0) ? 150 : 12);
    return tsi_pkg::DELTA_BITS'($urandom_range(0, 1) ? -mag : mag);
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  task automatic send_cmd(logic [1:0] cmd, logic signed [tsi_pkg::DELTA_BITS-1:0] dx,
                          logic signed [tsi_pkg::DELTA_BITS-1:0] dy, bit typed = 1'b0,
                          motion_res_t typed_res = '0);
    motion_res_t pred;
    int          gap;
    gap = ((n_sent / 100) % 3 == 1) ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_delta_x <= dx;
    in_delta_y <= dy;
    pred = interp_step(cmd, dx, dy);
    motion_q.push_back(typed ? typed_res : pred);
    do @(posedge clk); while (in_stall);
    n_sent++;
  endtask

  task automatic send_noise();
    send_cmd(2'($urandom_range(0, 3)), 24'($urandom()), 24'($urandom()));
  endtask

  // result transaction checker
  always @(posedge clk) begin
    motion_res_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_step_x, out_dir_x, out_step_y, out_dir_y,
             out_position_x, out_position_y, out_busy_res, out_accepted};
      n_rx++;
      if (motion_q.size() == 0) begin
        $display("%0t: unexpected result transaction, actual %h", $time, got);
        errors++;
      end else begin
        want = motion_q.pop_front();
        check_field("step_x", want.step_x, got.step_x);
        check_field("dir_x", want.dir_x, got.dir_x);
        check_field("step_y", want.step_y, got.step_y);
        check_field("dir_y", want.dir_y, got.dir_y);
        check_field("position_x", want.pos_x, got.pos_x);
        check_field("position_y", want.pos_y, got.pos_y);
        check_field("busy_res", want.busy, got.busy);
        check_field("accepted", want.accepted, got.accepted);
      end
    end
  end

  // output back-pressure, with one long hold-off
  initial begin
    int n;
    bit held;
    held = 1'b0;
    out_stall <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!held && n_rx >= 300) begin
        held = 1'b1;
        n    = 120;
      end else begin
        n = ((n_rx / 100) % 3 == 2) ? 0 : $urandom_range(0, 5);
      end
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int  sel;
    bit  paused;
    paused = 1'b0;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_command <= tsi_pkg::CMD_TICK;
    in_delta_x <= '0;
    in_delta_y <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (cmd_tbl[k])
      send_cmd(cmd_tbl[k].cmd, cmd_tbl[k].dx, cmd_tbl[k].dy, cmd_tbl[k].typed,
               cmd_tbl[k].res);

    while (n_sent < cmd_tbl.size() + RAND_CMDS) begin
      if (!paused && n_sent >= 500) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (motion_q.size() != 0);
      end
      sel = $urandom_range(0, 9);
      if (!moving) begin
        if (sel < 7) send_cmd(tsi_pkg::CMD_MOVE, short_delta(), short_delta());
        else if (sel == 7) send_cmd(tsi_pkg::CMD_HOME, 24'($urandom()), 24'($urandom()));
        else if (sel == 8) send_cmd(tsi_pkg::CMD_TICK, 24'($urandom()), 24'($urandom()));
        else send_cmd(CMD_NOP, 24'($urandom()), 24'($urandom()));
      end else begin
        if (sel < 8) send_cmd(tsi_pkg::CMD_TICK, 24'($urandom()), 24'($urandom()));
        else send_noise();
      end
    end

    // full-scale move; too long to finish, so it closes the run
    while (moving) send_cmd(tsi_pkg::CMD_TICK, '0, '0);
    send_cmd(tsi_pkg::CMD_MOVE, 24'sh800000, 24'sh7fffff);
    repeat (40) begin
      if ($urandom_range(0, 3) == 0) send_noise();
      else send_cmd(tsi_pkg::CMD_TICK, '0, '0);
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (motion_q.size() != 0);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("two_axis_step_interpolator_unit_test OK");
    end else begin
      $display("two_axis_step_interpolator_unit_test NOT OK");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/tsi_pkg.sv
rtl/core/tsi_axis.sv
rtl/core/two_axis_step_interpolator_unit.sv
verif/two_axis_step_interpolator_unit_test.sv
